>>> rtl/core/integer_neuron_sigmoid_macros.svh
// Assertion macros shared by the integer neuron sigmoid RTL.
`ifndef INTEGER_NEURON_SIGMOID_MACROS_SVH
`define INTEGER_NEURON_SIGMOID_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, switched off while reset is held.
`define ISN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("isn: assertion failed");
// Clocked implication, switched off while reset is held.
`define ISN_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("isn: implication failed");
`else
`define ISN_ASSERT(label, clk, rst_n, prop)
`define ISN_ASSERT_IMP(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/isn_pkg.sv
// Package with the types, constants and sigmoid table of the neuron.
package isn_pkg;

  localparam int NUM_INPUTS = 4;

  // Field widths.
  localparam int WORD_W   = 16;
  localparam int BIAS_W   = 32;
  localparam int ACTIVE_W = 3;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int PAIR_W   = PROD_W + 1;
  localparam int SUM_W    = 34;
  localparam int SIG_W    = 16;
  localparam int IDX_W    = 5;

  // Tree shape.
  localparam int NUM_PAIRS = (NUM_INPUTS + 1) / 2;

  // Register indexes on the configuration port.
  localparam int NUM_REGS  = NUM_INPUTS + 2;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_BIAS   = CFG_IDX_W'(NUM_INPUTS);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = CFG_IDX_W'(NUM_INPUTS + 1);
  localparam int CFG_DATA_W = BIAS_W;

  // Clamp limit of the sum before the table.
  localparam int SIG_LIMIT = 12;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef word_t [NUM_INPUTS-1:0] lane_vec_t;
  typedef prod_t [NUM_INPUTS-1:0] prod_vec_t;
  typedef pair_t [NUM_PAIRS-1:0]  pair_vec_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    word_t [NUM_INPUTS-1:0]   weight;
    logic signed [BIAS_W-1:0] bias;
    logic [ACTIVE_W-1:0]      active_inputs;
  } isn_cfg_t;

  // Logistic sigmoid in unsigned Q0.16, rounded, indexed by sum + 12.
  function automatic logic [SIG_W-1:0] sig_lut(input logic [IDX_W-1:0] idx);
    logic [SIG_W-1:0] v;
    case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd1;
      5'd2:    v = 16'd3;
      5'd3:    v = 16'd8;
      5'd4:    v = 16'd22;
      5'd5:    v = 16'd60;
      5'd6:    v = 16'd162;
      5'd7:    v = 16'd439;
      5'd8:    v = 16'd1179;
      5'd9:    v = 16'd3108;
      5'd10:   v = 16'd7812;
      5'd11:   v = 16'd17625;
      5'd12:   v = 16'd32768;
      5'd13:   v = 16'd47911;
      5'd14:   v = 16'd57724;
      5'd15:   v = 16'd62428;
      5'd16:   v = 16'd64357;
      5'd17:   v = 16'd65097;
      5'd18:   v = 16'd65374;
      5'd19:   v = 16'd65476;
      5'd20:   v = 16'd65514;
      5'd21:   v = 16'd65528;
      5'd22:   v = 16'd65533;
      5'd23:   v = 16'd65535;
      5'd24:   v = 16'd65535;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/integer_neuron_sigmoid.sv
// Top level of the integer neuron with sigmoid activation.
//
// Usage: an input transaction on in_valid/in_ready carries one activation per
// lane. Lanes below active_inputs are multiplied by their weights, the products
// are summed with the bias, and the sum is returned on out_weighted_sum together
// with its sigmoid in unsigned Q0.16 on out_activation.
// Configuration is written on cfg_valid/cfg_ready with a register index and data:
// indexes 0 to 3 are the lane weights, 4 the bias and 5 active_inputs; higher
// indexes are ignored. cfg_ready is always high. Write only while no transaction
// is in flight.
// Pipeline: the multiplier stage, the pair adder stage, the bias adder stage and the
// table stage, each registered. Throughput: one transaction per cycle while the
// receiver is ready.
// Reset clears the configuration registers to zero and empties the pipeline; the data registers are not reset.
// When the receiver stalls, the output holds and the stages behind it fill up;
// in_ready drops only once every stage holds a transaction.
`include "integer_neuron_sigmoid_macros.svh"

module integer_neuron_sigmoid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [isn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [isn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [isn_pkg::WORD_W-1:0] in_act_0,
  input  logic signed [isn_pkg::WORD_W-1:0] in_act_1,
  input  logic signed [isn_pkg::WORD_W-1:0] in_act_2,
  input  logic signed [isn_pkg::WORD_W-1:0] in_act_3,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [isn_pkg::SIG_W-1:0]     out_activation,
  output logic signed [isn_pkg::SUM_W-1:0] out_weighted_sum
);
  import isn_pkg::*;

  isn_cfg_t  cfg_r;
  isn_cfg_t  cfg_nxt;
  lane_vec_t act_vec;
  prod_vec_t prod;
  logic      mult_valid;
  logic      mult_ready;
  sum_t      sum;
  logic      sum_valid;
  logic      sum_ready;
  sum_t      wsum;

  // Configuration registers; a write is taken in every cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          cfg_nxt.weight[i] = cfg_data[WORD_W-1:0];
        end
      end
      if (cfg_index == REG_BIAS) begin
        cfg_nxt.bias = cfg_data[BIAS_W-1:0];
      end
      if (cfg_index == REG_ACTIVE) begin
        cfg_nxt.active_inputs = cfg_data[ACTIVE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Lane ports gathered into one vector.
  assign act_vec[0] = in_act_0;
  assign act_vec[1] = in_act_1;
  assign act_vec[2] = in_act_2;
  assign act_vec[3] = in_act_3;

  isn_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_act    (act_vec),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .out_prod  (prod)
  );

  isn_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (mult_valid),
    .in_ready  (mult_ready),
    .in_prod   (prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum)
  );

  isn_act u_act (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sum_valid),
    .in_ready         (sum_ready),
    .in_sum           (sum),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_activation   (out_activation),
    .out_weighted_sum (wsum)
  );

  assign out_weighted_sum = wsum;

  // Back-pressure reaches the input only through a stalled output.
  `ISN_ASSERT_IMP(a_stall_from_output, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

>>> rtl/core/isn_mult.sv
// First pipeline stage: one signed multiplier per lane, inactive lanes zeroed.
module isn_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  isn_pkg::isn_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  isn_pkg::lane_vec_t  in_act,
  output logic                out_valid,
  input  logic                out_ready,
  output isn_pkg::prod_vec_t  out_prod
);
  import isn_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  prod_vec_t prod_r;
  prod_vec_t prod_nxt;
  logic      load;

  // The stage takes a transaction when it is empty or its content moves on.
  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // Lane products; a lane at or above the active count gives zero.
  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (ACTIVE_W'(i) < cfg.active_inputs) begin
        prod_nxt[i] = $signed(in_act[i]) * $signed(cfg.weight[i]);
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

>>> rtl/core/isn_sum.sv
// Second and third pipeline stages: pairwise adds, then the final sum with the bias.
module isn_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  isn_pkg::isn_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  isn_pkg::prod_vec_t  in_prod,
  output logic                out_valid,
  input  logic                out_ready,
  output isn_pkg::sum_t       out_sum
);
  import isn_pkg::*;

  logic      pair_valid_r;
  logic      pair_valid_nxt;
  pair_vec_t pair_r;
  pair_vec_t pair_nxt;
  logic      pair_ready;
  logic      sum_valid_r;
  logic      sum_valid_nxt;
  sum_t      sum_r;
  sum_t      sum_nxt;

  // Ready chain from the output backwards.
  assign pair_ready = !sum_valid_r || out_ready;
  assign in_ready   = !pair_valid_r || pair_ready;

  // Pairwise sums; an odd last lane passes on alone.
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    if (2 * p + 1 < NUM_INPUTS) begin : g_two
      assign pair_nxt[p] = PAIR_W'(in_prod[2*p]) + PAIR_W'(in_prod[2*p+1]);
    end else begin : g_one
      assign pair_nxt[p] = PAIR_W'(in_prod[2*p]);
    end
  end

  // Final sum of the pairs and the bias.
  always_comb begin
    sum_nxt = SUM_W'(cfg.bias);
    for (int p = 0; p < NUM_PAIRS; p++) begin
      sum_nxt = sum_nxt + SUM_W'(pair_r[p]);
    end
  end

  always_comb begin
    pair_valid_nxt = pair_valid_r;
    if (in_ready) begin
      pair_valid_nxt = in_valid;
    end
    sum_valid_nxt = sum_valid_r;
    if (pair_ready) begin
      sum_valid_nxt = pair_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      pair_valid_r <= pair_valid_nxt;
      sum_valid_r  <= sum_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pair_r <= pair_nxt;
    end
    if (pair_valid_r && pair_ready) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_sum   = sum_r;

endmodule

>>> rtl/core/isn_act.sv
// Last pipeline stage: clamp, sigmoid table and the output register.
`include "integer_neuron_sigmoid_macros.svh"

module isn_act (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  isn_pkg::sum_t             in_sum,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [isn_pkg::SIG_W-1:0] out_activation,
  output isn_pkg::sum_t             out_weighted_sum
);
  import isn_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [SIG_W-1:0] act_r;
  logic [SIG_W-1:0] act_nxt;
  sum_t             sum_r;
  logic [IDX_W-1:0] idx;

  assign in_ready = !valid_r || out_ready;

  // Clamp the sum to the table range and offset it to a table index.
  always_comb begin
    if (in_sum < -SUM_W'(SIG_LIMIT)) begin
      idx = '0;
    end else if (in_sum > SUM_W'(SIG_LIMIT)) begin
      idx = IDX_W'(2 * SIG_LIMIT);
    end else begin
      idx = in_sum[IDX_W-1:0] + IDX_W'(SIG_LIMIT);
    end
    act_nxt = sig_lut(idx);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= act_nxt;
      sum_r <= in_sum;
    end
  end

  assign out_valid        = valid_r;
  assign out_activation   = act_r;
  assign out_weighted_sum = sum_r;

  // A saturated sum must give the end values of the table.
  `ISN_ASSERT_IMP(a_high_saturates, clk, rst_n, valid_r && (sum_r > SUM_W'(SIG_LIMIT)), act_r == {SIG_W{1'b1}})
  `ISN_ASSERT_IMP(a_low_is_zero, clk, rst_n, valid_r && (sum_r < -SUM_W'(SIG_LIMIT)), act_r == '0)

endmodule

>>> tb/sv/integer_neuron_sigmoid_tb.sv
// Self-checking testbench for the integer neuron with sigmoid activation.
`timescale 1ns / 100ps

module integer_neuron_sigmoid_tb;
  import isn_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  localparam int LATENCY      = 4;
  localparam int DRAIN_CYCLES = LATENCY + 4;
  localparam int MAX_IDLE     = 18;
  localparam int RANDOM_ITEMS = 1700;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int TABLE_SIZE   = 2 * SIG_LIMIT + 1;

  // Register indexes not named by the package.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0       = '0;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_FIRST  = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LAST   = '1;

  // Logistic sigmoid in Q0.16 for sums from -12 to +12, top end saturated.
  localparam logic [SIG_W-1:0] SIGMOID_Q16 [TABLE_SIZE] = '{
    16'd0, 16'd1, 16'd3, 16'd8, 16'd22, 16'd60, 16'd162, 16'd439, 16'd1179,
    16'd3108, 16'd7812, 16'd17625, 16'd32768, 16'd47911, 16'd57724, 16'd62428,
    16'd64357, 16'd65097, 16'd65374, 16'd65476, 16'd65514, 16'd65528,
    16'd65533, 16'd65535, 16'd65535
  };

  // Shapes of the random stimulus: sums near the sigmoid knee, full range,
  // and corner values only.
  typedef enum logic [1:0] {MIX_WINDOW, MIX_FULL, MIX_EXTREME} mix_t;

  // Predicts each result from its input transaction and checks it in order.
  class neuron_scoreboard;
    typedef struct {
      logic [SIG_W-1:0]        activation;
      logic signed [SUM_W-1:0] weighted_sum;
    } neuron_result_t;

    word_t                    weight [NUM_INPUTS];
    logic signed [BIAS_W-1:0] bias;
    logic [ACTIVE_W-1:0]      active_inputs;
    neuron_result_t           expected_q [$];
    bit                       table_hit [TABLE_SIZE];
    int unsigned              errors;
    int unsigned              inputs_seen;
    int unsigned              results_checked;
    int unsigned              cfg_writes;

    function new();
      foreach (weight[i]) weight[i] = '0;
      bias          = '0;
      active_inputs = '0;
      errors          = 0;
      inputs_seen     = 0;
      results_checked = 0;
      cfg_writes      = 0;
    endfunction

    // Mirrors a register write; unknown indexes leave everything alone.
    function void note_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
      if (idx < NUM_INPUTS) weight[idx] = data[WORD_W-1:0];
      else if (idx == REG_BIAS) bias = data[BIAS_W-1:0];
      else if (idx == REG_ACTIVE) active_inputs = data[ACTIVE_W-1:0];
      cfg_writes++;
    endfunction

    // Dot product over the active lanes plus bias, clamped into the table.
    function void note_input(input lane_vec_t acts);
      int unsigned    lanes;
      longint         acc;
      longint         clamped;
      neuron_result_t r;
      lanes = (active_inputs > NUM_INPUTS) ? NUM_INPUTS : active_inputs;
      acc = longint'(signed'(bias));
      for (int i = 0; i < lanes; i++)
        acc += longint'(signed'(weight[i])) * longint'(signed'(acts[i]));
      clamped = acc;
      if (clamped < -SIG_LIMIT) clamped = -SIG_LIMIT;
      if (clamped > SIG_LIMIT) clamped = SIG_LIMIT;
      r.activation   = SIGMOID_Q16[clamped + SIG_LIMIT];
      r.weighted_sum = SUM_W'(acc);
      table_hit[clamped + SIG_LIMIT] = 1'b1;
      expected_q.push_back(r);
      inputs_seen++;
    endfunction

    // Compares an output transaction with the oldest prediction.
    function void check_result(input logic [SIG_W-1:0] activation,
                               input logic signed [SUM_W-1:0] weighted_sum);
      neuron_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: activation %0d, weighted_sum %0d",
               activation, weighted_sum);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      results_checked++;
      if (activation !== r.activation) begin
        $error("activation: expected %0d, actual %0d", r.activation, activation);
        errors++;
      end
      if (weighted_sum !== r.weighted_sum) begin
        $error("weighted_sum: expected %0d, actual %0d", r.weighted_sum, weighted_sum);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int table_coverage();
      int n;
      n = 0;
      foreach (table_hit[i]) if (table_hit[i]) n++;
      return n;
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [WORD_W-1:0]      in_act_0  = '0;
  logic signed [WORD_W-1:0]      in_act_1  = '0;
  logic signed [WORD_W-1:0]      in_act_2  = '0;
  logic signed [WORD_W-1:0]      in_act_3  = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [SIG_W-1:0]              out_activation;
  logic signed [SUM_W-1:0]       out_weighted_sum;

  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  neuron_scoreboard sb = new();

  integer_neuron_sigmoid u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_act_0         (in_act_0),
    .in_act_1         (in_act_1),
    .in_act_2         (in_act_2),
    .in_act_3         (in_act_3),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_activation   (out_activation),
    .out_weighted_sum (out_weighted_sum)
  );

  always #(CLK_HALF) clk = ~clk;

  // Every completed transaction on the three channels is seen here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_activation, out_weighted_sum);
      if (in_valid && in_ready)
        sb.note_input({in_act_3, in_act_2, in_act_1, in_act_0});
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  // The receiver stalls for a random number of cycles before each result.
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk);
      stall = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one input transaction after a random gap and waits for acceptance.
  task automatic send_item(input lane_vec_t acts);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_act_0 <= acts[0];
    in_act_1 <= acts[1];
    in_act_2 <= acts[2];
    in_act_3 <= acts[3];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops the input stream and lets the pipeline empty completely.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Loads all registers, with junk in the unused upper data bits.
  task automatic set_neuron(input lane_vec_t w, input logic signed [BIAS_W-1:0] b,
                            input logic [ACTIVE_W-1:0] lanes);
    wait_idle();
    for (int i = 0; i < NUM_INPUTS; i++)
      write_reg(REG_WEIGHT_0 + CFG_IDX_W'(i),
                {(CFG_DATA_W - WORD_W)'($urandom), w[i]});
    write_reg(REG_BIAS, b);
    write_reg(REG_ACTIVE, {(CFG_DATA_W - ACTIVE_W)'($urandom), lanes});
  endtask

  function automatic word_t pick_corner();
    case ($urandom_range(0, 4))
      0:       return word_t'(16'sh8000);
      1:       return word_t'(16'sh7FFF);
      2:       return word_t'(0);
      3:       return word_t'(-1);
      default: return word_t'(1);
    endcase
  endfunction

  function automatic lane_vec_t draw_lanes(input mix_t kind);
    lane_vec_t v;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      case (kind)
        MIX_WINDOW: v[i] = word_t'(int'($urandom_range(0, 8)) - 4);
        MIX_FULL:   v[i] = word_t'($urandom);
        default:    v[i] = pick_corner();
      endcase
    end
    return v;
  endfunction

  // Reset, directed corner cases, then randomly configured phases.
  initial begin
    word_t                    lane0_probe [7];
    lane_vec_t                acts;
    lane_vec_t                weights;
    logic signed [BIAS_W-1:0] b;
    logic [ACTIVE_W-1:0]      lanes;
    mix_t                     kind;
    int unsigned              sent;
    int unsigned              phase_len;
    int unsigned              pick;

    lane0_probe = '{-32768, -13, -12, 0, 12, 13, 32767};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: no lane is active and the bias is zero.
    send_item({NUM_INPUTS{word_t'(16'sh7FFF)}});
    send_item({NUM_INPUTS{word_t'(16'sh8000)}});

    // Single lane of weight one walks the clamp edges; other lanes carry noise.
    set_neuron({word_t'(0), word_t'(0), word_t'(0), word_t'(1)}, 32'sd0, 3'd1);
    foreach (lane0_probe[i]) begin
      acts    = draw_lanes(MIX_FULL);
      acts[0] = lane0_probe[i];
      send_item(acts);
    end

    // Largest positive sum, then a large negative one.
    set_neuron({NUM_INPUTS{word_t'(16'sh8000)}}, 32'sh7FFF_FFFF, 3'd4);
    send_item({NUM_INPUTS{word_t'(16'sh8000)}});
    send_item({NUM_INPUTS{word_t'(16'sh7FFF)}});

    // Most negative sum, with an oversized lane count that must saturate.
    set_neuron({NUM_INPUTS{word_t'(16'sh8000)}}, 32'sh8000_0000, 3'd7);
    send_item({NUM_INPUTS{word_t'(16'sh7FFF)}});
    send_item({NUM_INPUTS{word_t'(16'sh8000)}});

    // No active lanes: the sum is the bias alone.
    set_neuron({NUM_INPUTS{word_t'(16'sh7FFF)}}, -32'sd7, 3'd0);
    send_item(draw_lanes(MIX_FULL));

    // Writes beyond the register list must change nothing.
    wait_idle();
    write_reg(REG_UNKNOWN_FIRST, $urandom);
    write_reg(REG_UNKNOWN_LAST, $urandom);
    send_item(draw_lanes(MIX_FULL));

    // A lane count just above the lane total.
    wait_idle();
    write_reg(REG_ACTIVE, {(CFG_DATA_W - ACTIVE_W)'($urandom), 3'd5});
    send_item({NUM_INPUTS{word_t'(1)}});

    // Mixed small weights around the sigmoid knee.
    set_neuron({word_t'(4), word_t'(2), word_t'(-3), word_t'(1)}, -32'sd5, 3'd4);
    repeat (3) send_item(draw_lanes(MIX_WINDOW));

    // Random phases, each with its own register setting and idling pattern.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 5) ? MIX_WINDOW : ((pick < 8) ? MIX_FULL : MIX_EXTREME);
      for (int i = 0; i < NUM_INPUTS; i++) begin
        case (kind)
          MIX_WINDOW: weights[i] = word_t'(int'($urandom_range(0, 6)) - 3);
          MIX_FULL:   weights[i] = word_t'($urandom);
          default:    weights[i] = pick_corner();
        endcase
      end
      case (kind)
        MIX_WINDOW: b = int'($urandom_range(0, 16)) - 8;
        MIX_FULL:   b = $urandom;
        default: begin
          case ($urandom_range(0, 3))
            0:       b = 32'sh8000_0000;
            1:       b = 32'sh7FFF_FFFF;
            2:       b = -32'sd1;
            default: b = 32'sd0;
          endcase
        end
      endcase
      lanes = ($urandom_range(0, 1) == 0) ? ACTIVE_W'(NUM_INPUTS)
                                          : ACTIVE_W'($urandom_range(0, 7));
      set_neuron(weights, b, lanes);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        send_item(draw_lanes(kind));
        sent++;
      end
    end

    wait_idle();
    $display("Run covered %0d input transactions, %0d results checked, %0d register writes.",
             sb.inputs_seen, sb.results_checked, sb.cfg_writes);
    $display("Sigmoid table entries reached: %0d of %0d.", sb.table_coverage(), TABLE_SIZE);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
